### rtl/core/tlpm_pkg.sv
// Shared types, widths and constants for the tree LCA path min/max engine.
// Used by every module under rtl/core; depends on nothing.
package tlpm_pkg;

  localparam int NODE_W  = 11;
  localparam int WGT_W   = 31;
  localparam int MAXV_W  = 32;
  localparam int DEPTH_W = 10;
  localparam int KIND_W  = 2;

  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 11;

  localparam logic [WGT_W-1:0]  EMPTY_MIN = '1;
  localparam logic [MAXV_W-1:0] EMPTY_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_BLD_INIT,
    S_BLD_LVL,
    S_BLD_RD1,
    S_BLD_RD2,
    S_BLD_WR,
    S_Q_DA,
    S_Q_DB,
    S_Q_SWAP,
    S_LIFT,
    S_LIFT_UP,
    S_EQ,
    S_SRCH_A,
    S_SRCH_B,
    S_SRCH_CMP,
    S_DSC,
    S_DSC_B,
    S_DSC_CMP,
    S_DSC_TB,
    S_PW_A,
    S_PW_B,
    S_PW_C,
    S_RES
  } state_t;

  // One jump/min/max table entry; wmax holds a two's complement value.
  typedef struct packed {
    logic [NODE_W-1:0] jump;
    logic [WGT_W-1:0]  wmin;
    logic [MAXV_W-1:0] wmax;
  } tbl_word_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [WGT_W-1:0]   pw;
  } node_word_t;

endpackage

### rtl/core/tlpm_mem.sv
// Jump/min/max table memory and per-node depth/weight memory.
// One write and one registered read port each; uses tlpm_pkg.
module tlpm_mem import tlpm_pkg::*; #(
  parameter int TA_W      = 15,
  parameter int TBL_DEPTH = 16400,
  parameter int RW        = 11,
  parameter int ROWS      = 1025
) (
  input  logic            clk,
  input  logic            tbl_we,
  input  logic [TA_W-1:0] tbl_waddr,
  input  tbl_word_t       tbl_wdata,
  input  logic [TA_W-1:0] tbl_raddr,
  output tbl_word_t       tbl_rdata,
  input  logic            node_we,
  input  logic [RW-1:0]   node_waddr,
  input  node_word_t      node_wdata,
  input  logic [RW-1:0]   node_raddr,
  output node_word_t      node_rdata
);

  tbl_word_t  tbl_mem  [TBL_DEPTH];
  node_word_t node_mem [ROWS];

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata <= node_mem[node_raddr];
  end

endmodule

### rtl/core/tlpm_alu.sv
// Shared min/max fold unit: merges a new weight pair into a running pair.
// Uses tlpm_pkg widths.
module tlpm_alu import tlpm_pkg::*; (
  input  logic [WGT_W-1:0]  acc_min,
  input  logic [MAXV_W-1:0] acc_max,
  input  logic [WGT_W-1:0]  new_min,
  input  logic [MAXV_W-1:0] new_max,
  output logic [WGT_W-1:0]  res_min,
  output logic [MAXV_W-1:0] res_max
);

  assign res_min = (new_min < acc_min) ? new_min : acc_min;
  assign res_max = ($signed(new_max) > $signed(acc_max)) ? new_max : acc_max;

endmodule

### rtl/core/tlpm_ctrl.sv
// Sequencer for clear, load, build and query; drives the memories and ALU.
// Depends on tlpm_pkg, tlpm_mem and tlpm_alu.
module tlpm_ctrl import tlpm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [NODE_W-1:0]   in_node,
  input  logic [NODE_W-1:0]   in_parent,
  input  logic [WGT_W-1:0]    in_weight,
  input  logic [DEPTH_W-1:0]  in_depth,
  input  logic [NODE_W-1:0]   in_other_node,
  input  logic [$clog2(MAX_NODES+1)-1:0] n_lim,
  output logic                out_valid,
  output logic [NODE_W-1:0]   out_ancestor,
  output logic [WGT_W-1:0]    out_path_min,
  output logic [MAXV_W-1:0]   out_path_max
);

  localparam int RW        = $clog2(MAX_NODES + 1);
  localparam int ROWS      = MAX_NODES + 1;
  localparam int LW        = $clog2(LEVELS);
  localparam int CW        = $clog2(LEVELS + 1);
  localparam int TA_W      = RW + LW;
  localparam int TBL_DEPTH = ROWS * (1 << LW);
  localparam logic [TA_W-1:0] CLR_LAST = TA_W'(TBL_DEPTH - 1);
  localparam logic [CW-1:0]   LVL_END  = CW'(LEVELS);

  state_t state_r, state_nxt;
  logic [RW-1:0]      a_r, a_nxt, b_r, b_nxt, i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [DEPTH_W-1:0] da_r, da_nxt, diff_r, diff_nxt, lift_sh;
  tbl_word_t          wa_r, wa_nxt, wb_r, wb_nxt;
  logic [WGT_W-1:0]   rmin_r, rmin_nxt;
  logic [MAXV_W-1:0]  rmax_r, rmax_nxt;
  logic [TA_W-1:0]    clr_r, clr_nxt;
  logic               ov_r, ov_nxt;
  logic [NODE_W-1:0]  anc_r, anc_nxt;
  logic [WGT_W-1:0]   pmin_r, pmin_nxt;
  logic [MAXV_W-1:0]  pmax_r, pmax_nxt;

  logic            tbl_we, node_we;
  logic [TA_W-1:0] tbl_waddr, tbl_raddr;
  tbl_word_t       tbl_wdata, tbl_rdata;
  logic [RW-1:0]   node_waddr, node_raddr;
  node_word_t      node_wdata, node_rdata;

  logic [WGT_W-1:0]  acc_min, new_min, alu_min;
  logic [MAXV_W-1:0] acc_max, new_max, alu_max;

  logic [RW-1:0]     fix_a, fix_b, up_row;
  logic [NODE_W-1:0] fix_par;
  logic [CW-1:0]     jm1;
  logic [DEPTH_W-1:0] db;

  tlpm_mem #(
    .TA_W(TA_W), .TBL_DEPTH(TBL_DEPTH), .RW(RW), .ROWS(ROWS)
  ) u_mem (
    .clk, .tbl_we, .tbl_waddr, .tbl_wdata, .tbl_raddr, .tbl_rdata,
    .node_we, .node_waddr, .node_wdata, .node_raddr, .node_rdata
  );

  tlpm_alu u_alu (
    .acc_min, .acc_max, .new_min, .new_max, .res_min(alu_min), .res_max(alu_max)
  );

  // Nodes above the table map to the node above the root.
  assign fix_a   = (32'(in_node) > 32'(MAX_NODES)) ? '0 : RW'(in_node);
  assign fix_b   = (32'(in_other_node) > 32'(MAX_NODES)) ? '0 : RW'(in_other_node);
  assign fix_par = (32'(in_parent) > 32'(MAX_NODES)) ? '0 : in_parent;
  assign up_row  = RW'(tbl_rdata.jump);
  assign jm1     = j_r - 1'b1;
  assign lift_sh = diff_r >> j_r;
  assign db      = node_rdata.depth;
  assign busy    = (state_r != S_IDLE);

  assign out_valid    = ov_r;
  assign out_ancestor = anc_r;
  assign out_path_min = pmin_r;
  assign out_path_max = pmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    da_r   <= da_nxt;
    diff_r <= diff_nxt;
    wa_r   <= wa_nxt;
    wb_r   <= wb_nxt;
    rmin_r <= rmin_nxt;
    rmax_r <= rmax_nxt;
    anc_r  <= anc_nxt;
    pmin_r <= pmin_nxt;
    pmax_r <= pmax_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r;  b_nxt = b_r;  i_nxt = i_r;  j_nxt = j_r;
    da_nxt = da_r;  diff_nxt = diff_r;
    wa_nxt = wa_r;  wb_nxt = wb_r;
    rmin_nxt = rmin_r;  rmax_nxt = rmax_r;
    clr_nxt = clr_r;
    ov_nxt = 1'b0;
    anc_nxt = anc_r;  pmin_nxt = pmin_r;  pmax_nxt = pmax_r;
    tbl_we = 1'b0;  tbl_waddr = '0;  tbl_wdata = '0;  tbl_raddr = '0;
    node_we = 1'b0; node_waddr = '0; node_wdata = '0; node_raddr = '0;
    acc_min = rmin_r;  acc_max = rmax_r;
    new_min = tbl_rdata.wmin;  new_max = tbl_rdata.wmax;

    case (state_r)
      S_CLR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        node_we   = (clr_r[LW-1:0] == '0);
        node_waddr = clr_r[TA_W-1:LW];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (kind_t'(in_kind))
            KIND_LOAD: begin
              if (fix_a != '0) begin
                tbl_we     = 1'b1;
                tbl_waddr  = {fix_a, {LW{1'b0}}};
                tbl_wdata  = '{jump: fix_par, wmin: in_weight, wmax: {1'b0, in_weight}};
                node_we    = 1'b1;
                node_waddr = fix_a;
                node_wdata = '{depth: in_depth, pw: in_weight};
              end
            end
            KIND_BUILD: begin
              // fetch the root's depth so the build can keep it
              node_raddr = RW'(1);
              state_nxt  = S_BLD_INIT;
            end
            KIND_QUERY: begin
              a_nxt = fix_a;
              b_nxt = fix_b;
              rmin_nxt = EMPTY_MIN;
              rmax_nxt = EMPTY_MAX;
              state_nxt = S_Q_DA;
            end
            default: ;
          endcase
        end
      end
      // Root row: no parent, empty weights.
      S_BLD_INIT: begin
        tbl_we     = 1'b1;
        tbl_waddr  = {RW'(1), {LW{1'b0}}};
        tbl_wdata  = '{jump: '0, wmin: EMPTY_MIN, wmax: EMPTY_MAX};
        j_nxt      = CW'(1);
        state_nxt  = S_BLD_LVL;
        // keep the root's depth, zero its edge weight
        node_we    = 1'b1;
        node_waddr = RW'(1);
        node_wdata = '{depth: node_rdata.depth, pw: '0};
      end
      S_BLD_LVL: begin
        if ((j_r < LVL_END) && ((32'd1 << j_r) <= 32'(n_lim))) begin
          i_nxt = RW'(1);
          state_nxt = S_BLD_RD1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BLD_RD1: begin
        tbl_raddr = {i_r, jm1[LW-1:0]};
        state_nxt = S_BLD_RD2;
      end
      S_BLD_RD2: begin
        wa_nxt    = tbl_rdata;
        tbl_raddr = {up_row, jm1[LW-1:0]};
        state_nxt = S_BLD_WR;
      end
      S_BLD_WR: begin
        acc_min   = wa_r.wmin;
        acc_max   = wa_r.wmax;
        tbl_we    = 1'b1;
        tbl_waddr = {i_r, j_r[LW-1:0]};
        tbl_wdata = '{jump: tbl_rdata.jump, wmin: alu_min, wmax: alu_max};
        if (i_r == n_lim) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_BLD_LVL;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_BLD_RD1;
        end
      end
      S_Q_DA: begin
        node_raddr = a_r;
        state_nxt  = S_Q_DB;
      end
      S_Q_DB: begin
        da_nxt     = node_rdata.depth;
        node_raddr = b_r;
        state_nxt  = S_Q_SWAP;
      end
      S_Q_SWAP: begin
        if (da_r < db) begin
          a_nxt = b_r;
          b_nxt = a_r;
          diff_nxt = db - da_r;
        end else begin
          diff_nxt = da_r - db;
        end
        j_nxt = '0;
        state_nxt = S_LIFT;
      end
      S_LIFT: begin
        if (j_r == LVL_END) begin
          state_nxt = S_EQ;
        end else if (lift_sh[0]) begin
          tbl_raddr = {a_r, j_r[LW-1:0]};
          state_nxt = S_LIFT_UP;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_LIFT_UP: begin
        rmin_nxt = alu_min;
        rmax_nxt = alu_max;
        a_nxt = up_row;
        j_nxt = j_r + 1'b1;
        state_nxt = S_LIFT;
      end
      S_EQ: begin
        if (a_r == b_r) begin
          ov_nxt   = 1'b1;
          anc_nxt  = NODE_W'(a_r);
          pmin_nxt = rmin_r;
          pmax_nxt = rmax_r;
          state_nxt = S_IDLE;
        end else begin
          j_nxt = '0;
          state_nxt = S_SRCH_A;
        end
      end
      S_SRCH_A: begin
        if (j_r == LVL_END) begin
          state_nxt = S_DSC;
        end else begin
          tbl_raddr = {a_r, j_r[LW-1:0]};
          state_nxt = S_SRCH_B;
        end
      end
      S_SRCH_B: begin
        wa_nxt    = tbl_rdata;
        tbl_raddr = {b_r, j_r[LW-1:0]};
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (wa_r.jump == tbl_rdata.jump) begin
          state_nxt = S_DSC;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_SRCH_A;
        end
      end
      S_DSC: begin
        if (j_r == '0) begin
          state_nxt = S_PW_A;
        end else begin
          j_nxt     = jm1;
          tbl_raddr = {a_r, jm1[LW-1:0]};
          state_nxt = S_DSC_B;
        end
      end
      S_DSC_B: begin
        wa_nxt    = tbl_rdata;
        tbl_raddr = {b_r, j_r[LW-1:0]};
        state_nxt = S_DSC_CMP;
      end
      S_DSC_CMP: begin
        new_min = wa_r.wmin;
        new_max = wa_r.wmax;
        if (wa_r.jump != tbl_rdata.jump) begin
          rmin_nxt = alu_min;
          rmax_nxt = alu_max;
          wb_nxt   = tbl_rdata;
          state_nxt = S_DSC_TB;
        end else begin
          state_nxt = S_DSC;
        end
      end
      S_DSC_TB: begin
        new_min  = wb_r.wmin;
        new_max  = wb_r.wmax;
        rmin_nxt = alu_min;
        rmax_nxt = alu_max;
        a_nxt = RW'(wa_r.jump);
        b_nxt = RW'(wb_r.jump);
        state_nxt = S_DSC;
      end
      S_PW_A: begin
        node_raddr = a_r;
        state_nxt  = S_PW_B;
      end
      S_PW_B: begin
        new_min  = node_rdata.pw;
        new_max  = {1'b0, node_rdata.pw};
        rmin_nxt = alu_min;
        rmax_nxt = alu_max;
        node_raddr = b_r;
        state_nxt  = S_PW_C;
      end
      S_PW_C: begin
        new_min  = node_rdata.pw;
        new_max  = {1'b0, node_rdata.pw};
        rmin_nxt = alu_min;
        rmax_nxt = alu_max;
        tbl_raddr = {a_r, {LW{1'b0}}};
        state_nxt = S_RES;
      end
      S_RES: begin
        ov_nxt   = 1'b1;
        anc_nxt  = tbl_rdata.jump;
        pmin_nxt = rmin_r;
        pmax_nxt = rmax_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/core/tree_lca_path_min_max.sv
// Top level of the binary-lifting LCA engine with path min/max.
// Holds the node_count register; depends on tlpm_pkg and tlpm_ctrl.
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------
//  input   | start / busy     | in_kind in_node in_parent in_weight
//          |                  | in_depth in_other_node
//  result  | out_valid strobe | out_ancestor out_path_min out_path_max
//  config  | cfg_we           | cfg_wdata (node_count)
//
// A word is taken on start while busy is low. Load words finish in the
// taking cycle. A query keeps busy high while it fetches both depths,
// lifts the deeper node, searches for the first common jump, descends
// and adds the last edge weights; the result strobe follows in the first
// idle cycle. A build reads two entries and writes one per node and
// level. Every step is bounded by the single read port of the jump/min/max
// table. After reset the block sweeps the tables to zero with busy high.
// Results are strobed for one cycle; the receiver cannot stall, so none is
// held.
module tree_lca_path_min_max import tlpm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [NODE_W-1:0]  in_node,
  input  logic [NODE_W-1:0]  in_parent,
  input  logic [WGT_W-1:0]   in_weight,
  input  logic [DEPTH_W-1:0] in_depth,
  input  logic [NODE_W-1:0]  in_other_node,
  input  logic               cfg_we,
  input  logic [NODE_W-1:0]  cfg_wdata,
  output logic               out_valid,
  output logic [NODE_W-1:0]  out_ancestor,
  output logic [WGT_W-1:0]   out_path_min,
  output logic [MAXV_W-1:0]  out_path_max
);

  localparam int RW = $clog2(MAX_NODES + 1);

  logic [NODE_W-1:0] node_count_r;
  logic [RW-1:0]     n_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(1);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // Clamp the node count to the table size.
  assign n_lim = (32'(node_count_r) > 32'(MAX_NODES)) ? RW'(MAX_NODES) : RW'(node_count_r);

  tlpm_ctrl #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_ctrl (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_node, .in_parent, .in_weight, .in_depth, .in_other_node,
    .n_lim,
    .out_valid, .out_ancestor, .out_path_min, .out_path_max
  );

  // A result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // A query keeps the block busy after it is taken.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_QUERY) |=> busy) else $error("query not started");

  // A result only follows busy work, and the block is free when it shows.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy))) else $error("result without work");

endmodule

### sim/tb_tree_lca_path_min_max.sv
// Self-checking bench for tree_lca_path_min_max: loads trees, builds, queries.
// Depends on tlpm_pkg and the RTL top level; holds its own lifting model.
`timescale 1ns / 100ps

module tb_tree_lca_path_min_max;
  import tlpm_pkg::*;

  localparam int NODES   = 1024;
  localparam int LV      = 11;
  localparam int ROWS    = NODES + 1;
  localparam int LIMIT   = 2500000;
  localparam logic [WGT_W-1:0] WMAX_IN = 31'h7FFF_FFFE;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0]  in_kind = '0;
  logic [NODE_W-1:0]  in_node = '0;
  logic [NODE_W-1:0]  in_parent = '0;
  logic [WGT_W-1:0]   in_weight = '0;
  logic [DEPTH_W-1:0] in_depth = '0;
  logic [NODE_W-1:0]  in_other_node = '0;
  logic               cfg_we = 1'b0;
  logic [NODE_W-1:0]  cfg_wdata = '0;
  logic               out_valid;
  logic [NODE_W-1:0]  out_ancestor;
  logic [WGT_W-1:0]   out_path_min;
  logic [MAXV_W-1:0]  out_path_max;

  tree_lca_path_min_max uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_node(in_node), .in_parent(in_parent),
    .in_weight(in_weight), .in_depth(in_depth), .in_other_node(in_other_node),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ancestor(out_ancestor),
    .out_path_min(out_path_min), .out_path_max(out_path_max)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // One expected query answer.
  typedef struct {
    logic [NODE_W-1:0]  anc;
    logic [WGT_W-1:0]   pmin;
    logic [MAXV_W-1:0]  pmax;
  } answer_t;

  answer_t lca_answers[$];

  // Shadow copy of the lifting tables and the node_count register.
  logic [NODE_W-1:0]        sh_jump [ROWS*LV];
  logic [WGT_W-1:0]         sh_min  [ROWS*LV];
  logic signed [MAXV_W-1:0] sh_max  [ROWS*LV];
  logic [DEPTH_W-1:0]       sh_depth[ROWS];
  logic [WGT_W-1:0]         sh_pw   [ROWS];
  logic [NODE_W-1:0]        sh_count;

  int errors = 0;
  int cycles = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_builds = 0;
  int burst_left = 0;

  // Depth of each node while generating well-formed loads.
  int tree_dep[ROWS];

  function automatic logic [NODE_W-1:0] clip_node(logic [NODE_W-1:0] v);
    return (v > NODES) ? '0 : v;
  endfunction

  function automatic void rebuild_tables();
    int n;
    int up;
    n = (sh_count > NODES) ? NODES : int'(sh_count);
    sh_jump[1*LV] = '0;
    sh_min[1*LV]  = EMPTY_MIN;
    sh_max[1*LV]  = -1;
    sh_pw[1]      = '0;
    for (int j = 1; j < LV && (1 << j) <= n; j++) begin
      for (int i = 1; i <= n; i++) begin
        up = int'(sh_jump[i*LV + j-1]);
        sh_jump[i*LV + j] = sh_jump[up*LV + j-1];
        sh_min[i*LV + j]  = (sh_min[i*LV + j-1] < sh_min[up*LV + j-1]) ?
                            sh_min[i*LV + j-1] : sh_min[up*LV + j-1];
        sh_max[i*LV + j]  = (sh_max[i*LV + j-1] > sh_max[up*LV + j-1]) ?
                            sh_max[i*LV + j-1] : sh_max[up*LV + j-1];
      end
    end
  endfunction

  function automatic answer_t lift_query(logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb);
    int a;
    int b;
    int t;
    int k;
    int diff;
    logic [WGT_W-1:0] rmin;
    logic signed [MAXV_W-1:0] rmax;
    answer_t r;
    a = int'(clip_node(na));
    b = int'(clip_node(nb));
    rmin = EMPTY_MIN;
    rmax = -1;
    if (sh_depth[a] < sh_depth[b]) begin
      t = a; a = b; b = t;
    end
    diff = int'(sh_depth[a]) - int'(sh_depth[b]);
    for (int j = 0; j < LV; j++) begin
      if (diff[j]) begin
        if (sh_min[a*LV+j] < rmin) rmin = sh_min[a*LV+j];
        if (sh_max[a*LV+j] > rmax) rmax = sh_max[a*LV+j];
        a = int'(sh_jump[a*LV+j]);
      end
    end
    if (a == b) begin
      r.anc = NODE_W'(a);
    end else begin
      k = 0;
      while (k < LV && sh_jump[a*LV+k] != sh_jump[b*LV+k]) k++;
      for (k = k - 1; k >= 0; k--) begin
        if (sh_jump[a*LV+k] != sh_jump[b*LV+k]) begin
          if (sh_min[a*LV+k] < rmin) rmin = sh_min[a*LV+k];
          if (sh_max[a*LV+k] > rmax) rmax = sh_max[a*LV+k];
          if (sh_min[b*LV+k] < rmin) rmin = sh_min[b*LV+k];
          if (sh_max[b*LV+k] > rmax) rmax = sh_max[b*LV+k];
          t = int'(sh_jump[a*LV+k]);
          b = int'(sh_jump[b*LV+k]);
          a = t;
        end
      end
      // Step the last edge on each side up to the common parent.
      if (sh_pw[a] < rmin) rmin = sh_pw[a];
      if ($signed({1'b0, sh_pw[a]}) > rmax) rmax = $signed({1'b0, sh_pw[a]});
      if (sh_pw[b] < rmin) rmin = sh_pw[b];
      if ($signed({1'b0, sh_pw[b]}) > rmax) rmax = $signed({1'b0, sh_pw[b]});
      r.anc = sh_jump[a*LV];
    end
    r.pmin = rmin;
    r.pmax = rmax;
    return r;
  endfunction

  // Apply one accepted word to the shadow state.
  function automatic void track_word(logic [KIND_W-1:0] k, logic [NODE_W-1:0] nd,
                                     logic [NODE_W-1:0] par, logic [WGT_W-1:0] w,
                                     logic [DEPTH_W-1:0] d, logic [NODE_W-1:0] od);
    if (k == KIND_LOAD) begin
      if (nd != 0 && nd <= NODES) begin
        sh_jump[nd*LV] = clip_node(par);
        sh_pw[nd]      = w;
        sh_min[nd*LV]  = w;
        sh_max[nd*LV]  = $signed({1'b0, w});
        sh_depth[nd]   = d;
      end
    end else if (k == KIND_BUILD) begin
      rebuild_tables();
      n_builds++;
    end else if (k == KIND_QUERY) begin
      lca_answers = {lca_answers, lift_query(nd, od)};
      n_queries++;
    end
  endfunction

  // Send one word; entered and left just after a rising edge.
  task automatic send_word(logic [KIND_W-1:0] k, int unsigned nd,
                           int unsigned par, int unsigned w,
                           int unsigned d, int unsigned od);
    int gap;
    logic [NODE_W-1:0]  nd_w;
    logic [NODE_W-1:0]  par_w;
    logic [WGT_W-1:0]   w_w;
    logic [DEPTH_W-1:0] d_w;
    logic [NODE_W-1:0]  od_w;
    nd_w  = NODE_W'(nd);
    par_w = NODE_W'(par);
    w_w   = WGT_W'(w);
    d_w   = DEPTH_W'(d);
    od_w  = NODE_W'(od);
    // Open a new burst after a random pause once the current one runs out.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start         <= 1'b1;
    in_kind       <= k;
    in_node       <= nd_w;
    in_parent     <= par_w;
    in_weight     <= w_w;
    in_depth      <= d_w;
    in_other_node <= od_w;
    // Hold until busy is seen low, then take the word at the next edge.
    do @(negedge clk); while (busy);
    @(posedge clk);
    track_word(k, nd_w, par_w, w_w, d_w, od_w);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for the block to drain before touching node_count.
  task automatic settle();
    release_start();
    while (lca_answers.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(int unsigned v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= NODE_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sh_count  = NODE_W'(v);
  endtask

  function automatic int unsigned pick_weight();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'(WMAX_IN);
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 7);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  // Load a random well-formed tree of n nodes; chain gives maximum depth.
  task automatic load_tree(int n, bit chain);
    int p;
    tree_dep[1] = 0;
    send_word(KIND_LOAD, 1, 0, pick_weight(), 0, $urandom);
    for (int i = 2; i <= n; i++) begin
      if (chain) p = i - 1;
      else if ($urandom_range(0, 2) == 0) p = $urandom_range((i > 4) ? i - 3 : 1, i - 1);
      else p = $urandom_range(1, i - 1);
      tree_dep[i] = tree_dep[p] + 1;
      send_word(KIND_LOAD, i, p, pick_weight(), tree_dep[i], $urandom);
    end
  endtask

  function automatic int unsigned pick_node(int n);
    case ($urandom_range(0, 15))
      0: return 0;
      1: return $urandom_range(NODES + 1, 2047);
      2: return (n < NODES) ? $urandom_range(n, NODES) : NODES;
      default: return $urandom_range(1, n);
    endcase
  endfunction

  task automatic run_queries(int n, int count);
    int unsigned a;
    for (int q = 0; q < count; q++) begin
      a = pick_node(n);
      send_word(KIND_QUERY, a, $urandom, $urandom,
                $urandom, ($urandom_range(0, 9) == 0) ? a : pick_node(n));
    end
  endtask

  // Tiny tree, extremes of every field, every kind of word.
  task automatic test_directed();
    write_count(1);
    send_word(KIND_QUERY, 1, 0, 0, 0, 1);          // equal nodes on empty tables
    send_word(KIND_QUERY, 0, 0, 0, 0, 2047);       // both beyond range or above root
    send_word(KIND_BUILD, 0, 0, 0, 0, 0);          // single-node build
    send_word(KIND_QUERY, 1, 0, 0, 0, 0);
    write_count(4);
    send_word(KIND_LOAD, 1, 0, 5, 0, 0);
    send_word(KIND_LOAD, 2, 1, 0, 1, 0);
    send_word(KIND_LOAD, 3, 1, 32'(WMAX_IN), 1, 0);
    send_word(KIND_LOAD, 4, 2, '1, 2, 0);
    send_word(KIND_LOAD, 0, 1, 9, 3, 0);           // node 0 load is dropped
    send_word(KIND_LOAD, 2047, 1, 9, 3, 0);        // out-of-range load is dropped
    send_word(KIND_LOAD, 5, 2047, 77, 1023, 0);    // parent clipped to 0, max depth
    send_word(KIND_QUERY, 4, 0, 0, 0, 3);          // before build: level 0 only
    send_word(KIND_BUILD, '1, '1, '1, '1, '1);
    send_word(KIND_QUERY, 4, '1, '1, '1, 3);
    send_word(KIND_QUERY, 2, 0, 0, 0, 4);
    send_word(KIND_QUERY, 3, 0, 0, 0, 3);
    send_word(KIND_QUERY, 5, 0, 0, 0, 1);          // node above node_count
    send_word(KIND_QUERY, 4, 0, 0, 0, 2047);
    send_word(2'd3, 4, 1, 1, 1, 3);                // unused kind
    send_word(KIND_QUERY, 1, 0, 0, 0, 4);
  endtask

  // Full-size chain: deepest lifting and widest build.
  task automatic test_full_chain();
    write_count(NODES);
    load_tree(NODES, 1'b1);
    send_word(KIND_BUILD, 0, 0, 0, 0, 0);
    run_queries(NODES, 40);
    write_count(2047);   // above the node limit, clipped inside
    send_word(KIND_BUILD, 0, 0, 0, 0, 0);
    run_queries(NODES, 10);
  endtask

  // A few small random trees with queries.
  task automatic test_random_trees();
    int n;
    for (int t = 0; t < 3; t++) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 160) : $urandom_range(2, 40);
      write_count(n);
      load_tree(n, ($urandom_range(0, 5) == 0));
      send_word(KIND_BUILD, 0, 0, 0, 0, 0);
      run_queries(n, $urandom_range(20, 30));
    end
  endtask

  // Noise: stray loads, unused kinds and rebuilds over broken trees.
  task automatic test_noise();
    int n;
    n = 24;
    write_count(n);
    load_tree(n, 1'b0);
    for (int i = 0; i < 150; i++) begin
      case ($urandom_range(0, 9))
        0: send_word(KIND_LOAD, pick_node(n), $urandom, pick_weight(), $urandom, $urandom);
        1: send_word(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: send_word(KIND_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: run_queries(n, 1);
      endcase
    end
  endtask

  // Result check on the falling edge, away from the block's updates.
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (lca_answers.size() == 0) begin
        $display("%0t: result with no query waiting: anc %0d min %0d max %0d",
                 $time, out_ancestor, out_path_min, $signed(out_path_max));
        errors++;
      end else begin
        if (out_ancestor !== lca_answers[0].anc) begin
          $display("%0t: ancestor expected %0d actual %0d",
                   $time, lca_answers[0].anc, out_ancestor);
          errors++;
        end
        if (out_path_min !== lca_answers[0].pmin) begin
          $display("%0t: path_min expected %0d actual %0d",
                   $time, lca_answers[0].pmin, out_path_min);
          errors++;
        end
        if (out_path_max !== lca_answers[0].pmax) begin
          $display("%0t: path_max expected %0d actual %0d", $time,
                   $signed(lca_answers[0].pmax), $signed(out_path_max));
          errors++;
        end
        void'(lca_answers.pop_front());
        n_checked++;
      end
    end
  end

  // Watchdog: the clearing sweep plus the slowest legal run fit well inside.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycles, lca_answers.size());
      $display("tb_tree_lca_path_min_max NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ROWS*LV; i++) begin
      sh_jump[i] = '0;
      sh_min[i]  = '0;
      sh_max[i]  = '0;
    end
    for (int i = 0; i < ROWS; i++) begin
      sh_depth[i] = '0;
      sh_pw[i]    = '0;
    end
    sh_count = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_chain();
    test_random_trees();
    test_noise();
    settle();
    repeat (100) @(posedge clk);
    if (lca_answers.size() != 0) begin
      $display("%0d query answers never arrived", lca_answers.size());
      errors++;
    end
    $display("covered %0d queries (%0d checked) over %0d builds, chain and random trees",
             n_queries, n_checked, n_builds);
    if (errors == 0) begin
      $display("tb_tree_lca_path_min_max OK");
    end else begin
      $display("tb_tree_lca_path_min_max NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tlpm_pkg.sv
rtl/core/tlpm_mem.sv
rtl/core/tlpm_alu.sv
rtl/core/tlpm_ctrl.sv
rtl/core/tree_lca_path_min_max.sv
sim/tb_tree_lca_path_min_max.sv
